[design/sorted_time_search_engine_unit_macros.svh]
// Assertion macros for the sorted time search engine checker
`ifndef SORTED_TIME_SEARCH_ENGINE_UNIT_MACROS_SVH
`define SORTED_TIME_SEARCH_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define STSE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stse check failed");

// next-cycle implication
`define STSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stse check failed");

`endif

[design/stse_pkg.sv]
// Shared types and constants for the sorted time search engine
`timescale 1ns / 1ps

package stse_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int KEY_W    = 25;
   localparam int DAY_W    = 9;
   localparam int RSP_IDX_W = 10;
   localparam int TARGET_W = 26;

   localparam int SEC_PER_DAY = 24 * 3600;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_PAIR   = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] time_key;
      logic [DAY_W-1:0] day_diff;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [RSP_IDX_W-1:0] first_index;
      logic [RSP_IDX_W-1:0] second_index;
   } rsp_type;

   // operands of the shared subtract/compare unit
   typedef struct packed {
      logic [KEY_W-1:0]    a_val;
      logic [KEY_W-1:0]    b_val;
      logic [TARGET_W-1:0] cmp_val;
   } alu_in_type;

   typedef struct packed {
      logic eq;
      logic lt;
   } alu_out_type;

endpackage

[design/stse_ram.sv]
// Timestamp table memory: one write port, one registered read port
`timescale 1ns / 1ps

module stse_ram #(
   parameter int DEPTH = stse_pkg::TABLE_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = stse_pkg::KEY_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/stse_alu.sv]
// Shared unit: saturating subtract then compare against a reference
`timescale 1ns / 1ps

module stse_alu (
   input  stse_pkg::alu_in_type  alu_in,
   output stse_pkg::alu_out_type alu_out
);

   logic [stse_pkg::TARGET_W-1:0] diff;

   // with a_val at zero this passes b_val straight on (lookup case)
   always_comb begin
      if (alu_in.b_val >= alu_in.a_val) begin
         diff = stse_pkg::TARGET_W'(alu_in.b_val - alu_in.a_val);
      end else begin
         diff = '0;
      end
      alu_out.eq = (diff == alu_in.cmp_val);
      alu_out.lt = (diff < alu_in.cmp_val);
   end

endmodule

[design/stse_seq.sv]
// Command sequencer: table fill count, binary search and two-pointer walk
`timescale 1ns / 1ps

module stse_seq #(
   parameter int TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF,
   parameter int IDX_W       = $clog2(TABLE_DEPTH),
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [1:0]                    cmd,
   input  logic [stse_pkg::KEY_W-1:0]    time_key,
   input  logic [stse_pkg::TARGET_W-1:0] target,
   output logic                          idle,
   output logic                          rsp_strobe,
   output stse_pkg::rsp_type             rsp_word,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [stse_pkg::KEY_W-1:0]    wr_data,
   output logic [IDX_W-1:0]              rd_addr,
   input  logic [stse_pkg::KEY_W-1:0]    rd_data,
   output stse_pkg::alu_in_type          alu_in,
   input  stse_pkg::alu_out_type         alu_out
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_LK_ADDR = 6'b000010,
      ST_LK_CMP  = 6'b000100,
      ST_PR_RDI  = 6'b001000,
      ST_PR_RDJ  = 6'b010000,
      ST_PR_CMP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hip1_ff, hip1_in;   // hi + 1, so an empty range needs no sign
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [stse_pkg::KEY_W-1:0] ti_ff, ti_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   stse_pkg::rsp_type rsp_ff, rsp_in;

   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic [CNT_W-1:0] i_step, j_step;
   logic [IDX_W+stse_pkg::RSP_IDX_W-1:0] first_ext, second_ext;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hip1_ff} - (CNT_W + 1)'(1);
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hip1_in       = hip1_ff;
      mid_in        = mid_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ti_in         = ti_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = time_key;
      rd_addr       = mid;
      alu_in.a_val  = '0;
      alu_in.b_val  = rd_data;
      alu_in.cmp_val = {1'b0, time_key};
      i_step        = i_ff;
      j_step        = j_ff;
      first_ext     = '0;
      second_ext    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               unique case (cmd)
                  stse_pkg::CMD_CLEAR: begin
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                  end
                  stse_pkg::CMD_APPEND: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        wr_en              = 1'b1;
                        count_in           = count_ff + CNT_W'(1);
                        first_ext          = {{stse_pkg::RSP_IDX_W{1'b0}},
                                              count_ff[IDX_W-1:0]};
                        rsp_in.found       = 1'b1;
                        rsp_in.first_index = first_ext[stse_pkg::RSP_IDX_W-1:0];
                     end
                  end
                  stse_pkg::CMD_LOOKUP: begin
                     lo_in    = '0;
                     hip1_in  = count_ff;
                     state_in = ST_LK_ADDR;
                  end
                  stse_pkg::CMD_PAIR: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = '0;
                     end else begin
                        i_in     = '0;
                        j_in     = CNT_W'(1);
                        state_in = ST_PR_RDI;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '0;
                  end
               endcase
            end
         end

         ST_LK_ADDR: begin
            if (lo_ff < hip1_ff) begin
               mid_in   = mid;
               state_in = ST_LK_CMP;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               state_in      = ST_IDLE;
            end
         end

         ST_LK_CMP: begin
            if (alu_out.eq) begin
               first_ext          = {{stse_pkg::RSP_IDX_W{1'b0}}, mid_ff};
               rsp_strobe_in      = 1'b1;
               rsp_in             = '0;
               rsp_in.found       = 1'b1;
               rsp_in.first_index = first_ext[stse_pkg::RSP_IDX_W-1:0];
               state_in           = ST_IDLE;
            end else begin
               if (alu_out.lt) begin
                  lo_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  hip1_in = CNT_W'(mid_ff);
               end
               state_in = ST_LK_ADDR;
            end
         end

         ST_PR_RDI: begin
            rd_addr = i_ff[IDX_W-1:0];
            if ((i_ff < count_ff) && (j_ff < count_ff)) begin
               state_in = ST_PR_RDJ;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               state_in      = ST_IDLE;
            end
         end

         ST_PR_RDJ: begin
            rd_addr  = j_ff[IDX_W-1:0];
            ti_in    = rd_data;
            state_in = ST_PR_CMP;
         end

         ST_PR_CMP: begin
            alu_in.a_val   = ti_ff;
            alu_in.cmp_val = target;
            if (alu_out.eq) begin
               first_ext           = {{stse_pkg::RSP_IDX_W{1'b0}}, i_ff[IDX_W-1:0]};
               second_ext          = {{stse_pkg::RSP_IDX_W{1'b0}}, j_ff[IDX_W-1:0]};
               rsp_strobe_in       = 1'b1;
               rsp_in.found        = 1'b1;
               rsp_in.first_index  = first_ext[stse_pkg::RSP_IDX_W-1:0];
               rsp_in.second_index = second_ext[stse_pkg::RSP_IDX_W-1:0];
               state_in            = ST_IDLE;
            end else begin
               if (alu_out.lt) begin
                  j_step = j_ff + CNT_W'(1);
               end else begin
                  i_step = i_ff + CNT_W'(1);
               end
               // pointers never share a slot
               if (i_step == j_step) begin
                  j_in = j_step + CNT_W'(1);
               end else begin
                  j_in = j_step;
               end
               i_in     = i_step;
               state_in = ST_PR_RDI;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hip1_ff <= hip1_in;
      mid_ff  <= mid_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      ti_ff   <= ti_in;
      rsp_ff  <= rsp_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

[design/sorted_time_search_engine_unit.sv]
// Clear, append, and pair search on fewer than two entries answer straight from idle; lookup
//   reads and compares one table entry per binary-search step; pair search reads both pointers, then compares.
// One command at a time: busy stays high until the result word is strobed.
// Pace set by the single read port of the table and the shared compare unit.
// Synchronous reset empties the table (count 0); table contents are not cleared.
// The receiver cannot stall: each result word is valid for one cycle only.
`timescale 1ns / 1ps

module sorted_time_search_engine_unit #(
   parameter int TABLE_DEPTH = stse_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  stse_pkg::req_type req_word,
   output logic              rsp_strobe,
   output stse_pkg::rsp_type rsp_word
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic go_ff, go_in;
   logic [1:0] cmd_ff;
   logic [stse_pkg::KEY_W-1:0] key_ff;
   logic [stse_pkg::TARGET_W-1:0] target_ff;
   logic seq_idle;
   logic accept;

   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic [stse_pkg::KEY_W-1:0] wr_data;
   logic [stse_pkg::KEY_W-1:0] rd_data;
   stse_pkg::alu_in_type  alu_in;
   stse_pkg::alu_out_type alu_out;

   assign busy   = go_ff | ~seq_idle;
   assign accept = start & ~busy;
   assign go_in  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
   end

   // day count to seconds once per word, ahead of the search
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_word.cmd;
         key_ff    <= req_word.time_key;
         target_ff <= stse_pkg::TARGET_W'(req_word.day_diff)
                      * stse_pkg::TARGET_W'(stse_pkg::SEC_PER_DAY);
      end
   end

   stse_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .go         (go_ff),
      .cmd        (cmd_ff),
      .time_key   (key_ff),
      .target     (target_ff),
      .idle       (seq_idle),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .alu_in     (alu_in),
      .alu_out    (alu_out)
   );

   stse_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   stse_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W),
      .DW    (stse_pkg::KEY_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

[design/stse_chk.sv]
// Port-level checker for the sorted time search engine, bound to the top level
`timescale 1ns / 1ps
`include "sorted_time_search_engine_unit_macros.svh"

module stse_chk (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input stse_pkg::rsp_type rsp_word
);

   `STSE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `STSE_ASSERT_IMPLY(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy))
   `STSE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `STSE_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_strobe && !rsp_word.found,
      (rsp_word.first_index == '0) && (rsp_word.second_index == '0))

endmodule

bind sorted_time_search_engine_unit stse_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
